[hw/rtl/assert_macros.svh]
// Assertion helpers shared by the RTL; clock i_clk, reset i_rst_n (active low).
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define GVPM_ASSERT_IMP(lbl, pre, post, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (post)) \
        else $error(msg);

// Next-cycle implication.
`define GVPM_ASSERT_NXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

[hw/rtl/gvpm_pkg.sv]
`timescale 1ns / 1ps

package gvpm_pkg;

    // Item kinds on the input tuser
    localparam logic [1:0] FUNC_TICK   = 2'd0;
    localparam logic [1:0] FUNC_START  = 2'd1;
    localparam logic [1:0] FUNC_SAMPLE = 2'd2;
    localparam logic [1:0] FUNC_FREEZE = 2'd3;

    // Result status codes
    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_FULL    = 2'd1;
    localparam logic [1:0] STAT_IGNORED = 2'd2;

    // Operations carried along the cell chain
    localparam logic [2:0] OP_NOP    = 3'd0;
    localparam logic [2:0] OP_TICK   = 3'd1;
    localparam logic [2:0] OP_START  = 3'd2;
    localparam logic [2:0] OP_SAMPLE = 3'd3;
    localparam logic [2:0] OP_FREEZE = 3'd4;

    // Port field widths
    localparam int FUNC_W = 2;
    localparam int GLEN_W = 11;
    localparam int SMP_W  = 16;
    localparam int GAIN_W = 16;
    localparam int MIX_W  = 19;
    localparam int STAT_W = 2;

    localparam int MIX_MAX = 262143;
    localparam int MIX_MIN = -262144;

    // Control part of the word handed from cell to cell
    typedef struct packed {
        logic       valid;
        logic [2:0] op;
        logic       drop;   // start: free the slot still loading
        logic       last;   // sample: final sample of the grain
        logic       flag;   // freeze: loop value
        logic       token;  // start: no slot claimed yet
    } t_ctl;

endpackage

[hw/rtl/gvpm_cell.sv]
`timescale 1ns / 1ps
`include "assert_macros.svh"

module gvpm_cell #(
    parameter int SLOTS       = 8,
    parameter int GRAIN_LEN   = 1024,
    parameter int SAMPLE_BITS = 16,
    parameter int MY_IDX      = 0
) (
    input  logic                                        i_clk,
    input  logic                                        i_rst_n,
    input  gvpm_pkg::t_ctl                              i_ctl,
    input  logic [((SLOTS > 1) ? $clog2(SLOTS) : 1)-1:0] i_idx,
    input  logic [((SLOTS > 1) ? $clog2(SLOTS) : 1)-1:0] i_claim,
    input  logic [SAMPLE_BITS-1:0]                      i_sample,
    input  logic [$clog2(GRAIN_LEN):0]                  i_len,
    input  logic [$clog2(GRAIN_LEN)-1:0]                i_addr,
    input  logic [SAMPLE_BITS+((SLOTS > 1) ? $clog2(SLOTS) : 1):0] i_sum,
    output gvpm_pkg::t_ctl                              o_ctl,
    output logic [((SLOTS > 1) ? $clog2(SLOTS) : 1)-1:0] o_idx,
    output logic [((SLOTS > 1) ? $clog2(SLOTS) : 1)-1:0] o_claim,
    output logic [SAMPLE_BITS-1:0]                      o_sample,
    output logic [$clog2(GRAIN_LEN):0]                  o_len,
    output logic [$clog2(GRAIN_LEN)-1:0]                o_addr,
    output logic [SAMPLE_BITS+((SLOTS > 1) ? $clog2(SLOTS) : 1):0] o_sum
);
    import gvpm_pkg::*;

    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int AW = $clog2(GRAIN_LEN);
    localparam int LW = AW + 1;
    localparam int SW = SAMPLE_BITS + IW + 1;
    localparam logic [IW-1:0] ME = IW'(MY_IDX);

    logic [SAMPLE_BITS-1:0] r_mem [GRAIN_LEN];
    logic [SAMPLE_BITS-1:0] r_rd;

    logic          r_busy, n_busy;
    logic          r_ready, n_ready;
    logic          r_loop, n_loop;
    logic [AW-1:0] r_pos, n_pos;
    logic [LW-1:0] r_len, n_len;

    t_ctl              r_ctl, n_ctl;
    logic [IW-1:0]     r_idx, r_claim, n_claim;
    logic [SAMPLE_BITS-1:0] r_sample;
    logic [LW-1:0]     r_len_o;
    logic [AW-1:0]     r_addr;
    logic [SW-1:0]     r_sum, n_sum;

    logic          w_hit;
    logic          w_eff_busy;
    logic          w_we;
    logic [LW-1:0] w_next;

    assign w_hit      = (i_idx == ME);
    assign w_eff_busy = r_busy && !(i_ctl.drop && w_hit);
    assign w_next     = {1'b0, r_pos} + LW'(1);

    always_comb begin
        n_busy  = r_busy;
        n_ready = r_ready;
        n_loop  = r_loop;
        n_pos   = r_pos;
        n_len   = r_len;
        n_ctl   = i_ctl;
        n_claim = i_claim;
        n_sum   = i_sum;
        w_we    = 1'b0;
        if (i_ctl.valid) begin
            case (i_ctl.op)
                OP_TICK: begin
                    if (r_busy && r_ready) begin
                        n_sum = i_sum + {{(SW-SAMPLE_BITS){r_rd[SAMPLE_BITS-1]}}, r_rd};
                        if (w_next >= r_len) begin
                            n_pos = '0;
                            if (!r_loop) begin
                                n_busy  = 1'b0;
                                n_ready = 1'b0;
                            end
                        end else begin
                            n_pos = w_next[AW-1:0];
                        end
                    end
                end
                OP_START: begin
                    if (i_ctl.token && !w_eff_busy) begin
                        n_busy    = 1'b1;
                        n_ready   = 1'b0;
                        n_pos     = '0;
                        n_len     = i_len;
                        n_loop    = 1'b0;
                        n_ctl.token = 1'b0;
                        n_claim   = ME;
                    end else if (i_ctl.drop && w_hit) begin
                        n_busy  = 1'b0;
                        n_ready = 1'b0;
                        n_pos   = '0;
                        n_loop  = 1'b0;
                    end
                end
                OP_SAMPLE: begin
                    if (w_hit) begin
                        w_we = 1'b1;
                        if (i_ctl.last) begin
                            n_ready = 1'b1;
                        end
                    end
                end
                OP_FREEZE: begin
                    if (r_busy) begin
                        n_loop = i_ctl.flag;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // grain memory: write port from the chain, read port follows the play position
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[i_addr] <= i_sample;
        end
        r_rd <= r_mem[r_pos];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_ready <= 1'b0;
            r_loop  <= 1'b0;
            r_pos   <= '0;
            r_len   <= '0;
            r_ctl   <= '0;
        end else begin
            r_busy  <= n_busy;
            r_ready <= n_ready;
            r_loop  <= n_loop;
            r_pos   <= n_pos;
            r_len   <= n_len;
            r_ctl   <= n_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx    <= i_idx;
        r_claim  <= n_claim;
        r_sample <= i_sample;
        r_len_o  <= i_len;
        r_addr   <= i_addr;
        r_sum    <= n_sum;
    end

    assign o_ctl    = r_ctl;
    assign o_idx    = r_idx;
    assign o_claim  = r_claim;
    assign o_sample = r_sample;
    assign o_len    = r_len_o;
    assign o_addr   = r_addr;
    assign o_sum    = r_sum;

    `GVPM_ASSERT_IMP(a_ready_busy, r_ready, r_busy, "slot ready but not busy")
    `GVPM_ASSERT_IMP(a_pos_len, r_busy, ({1'b0, r_pos} < r_len), "position past length")
    `GVPM_ASSERT_NXT(a_word_moves, i_ctl.valid, r_ctl.valid, "word lost in cell")

endmodule

[hw/rtl/grain_voice_pool_mixer_core.sv]
`timescale 1ns / 1ps
// Channel   Direction  Handshake                     Content
// s_axis    in         s_axis_tvalid/s_axis_tready   tuser func, tdata item fields
// m_axis    out        m_axis_tvalid/m_axis_tready   tdata mix_sum, tuser status
//
// One word in flight: accept, head register, the SLOTS slot cells, hold, output register;
// a new word is taken only once the previous result has moved to the output register.
// The word walks the chain of slot cells and is registered in every cell in turn.
// Reset is synchronous, active low; it empties every slot and the loading state.
// The next word is taken while a result still waits on m_axis; a stalled result
// holds the block only once a second result is ready behind it.
`include "assert_macros.svh"

module grain_voice_pool_mixer_core #(
    parameter int SLOTS       = 8,
    parameter int GRAIN_LEN   = 1024,
    parameter int SAMPLE_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // grain_length[10:0], sample[26:11], envelope_gain[42:27], repeat_flag[43], zero fill
    input  logic [47:0] s_axis_tdata,
    // func[1:0]
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // mix_sum[18:0], zero fill
    output logic [23:0] m_axis_tdata,
    // status[1:0]
    output logic [1:0]  m_axis_tuser
);
    import gvpm_pkg::*;

    localparam int IW  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int AW  = $clog2(GRAIN_LEN);
    localparam int LW  = AW + 1;
    localparam int SW  = SAMPLE_BITS + IW + 1;
    localparam int LXW = (LW > GLEN_W) ? LW : GLEN_W;
    localparam int MXW = (SW > MIX_W) ? SW : MIX_W;
    localparam int PW  = SMP_W + GAIN_W + 1;
    localparam int SMAX_I = (1 << (SAMPLE_BITS - 1)) - 1;
    localparam int SMIN_I = -(1 << (SAMPLE_BITS - 1));

    // unpack the input word
    logic [FUNC_W-1:0] w_func;
    logic [GLEN_W-1:0] w_glen;
    logic [SMP_W-1:0]  w_smp;
    logic [GAIN_W-1:0] w_gain;
    logic              w_rep;
    logic              w_acc;

    assign w_func = s_axis_tuser;
    assign w_glen = s_axis_tdata[10:0];
    assign w_smp  = s_axis_tdata[26:11];
    assign w_gain = s_axis_tdata[42:27];
    assign w_rep  = s_axis_tdata[43];
    assign w_acc  = s_axis_tvalid && s_axis_tready;

    // control and loading state
    logic          r_busy;
    logic          r_ld_active;
    logic [IW-1:0] r_ld_slot;
    logic [LW-1:0] r_ld_cnt;
    logic [LW-1:0] r_ld_len;

    // head of the chain
    t_ctl              r_head_ctl, n_head_ctl;
    logic [IW-1:0]     r_head_idx;
    logic [LW-1:0]     r_head_len;
    logic [AW-1:0]     r_head_addr;
    logic signed [PW-1:0] r_prod;
    logic [STAT_W-1:0] r_status, n_status;

    // result hold and output registers
    logic              r_hold_valid;
    logic [MIX_W-1:0]  r_hold_mix;
    logic [STAT_W-1:0] r_hold_status;
    logic              r_out_valid;
    logic [MIX_W-1:0]  r_out_mix;
    logic [STAT_W-1:0] r_out_status;

    // clamp the grain length into 1..GRAIN_LEN
    logic [LXW-1:0] w_len_x;
    always_comb begin
        w_len_x = LXW'(w_glen);
        if (w_len_x == '0) begin
            w_len_x = LXW'(1);
        end else if (w_len_x > LXW'(GRAIN_LEN)) begin
            w_len_x = LXW'(GRAIN_LEN);
        end
    end

    // decide what the word does in the cells
    logic [LW-1:0] w_cnt_inc;
    assign w_cnt_inc = r_ld_cnt + LW'(1);

    always_comb begin
        n_head_ctl       = '0;
        n_head_ctl.valid = 1'b1;
        n_status         = STAT_OK;
        case (w_func)
            FUNC_TICK: begin
                n_head_ctl.op = OP_TICK;
            end
            FUNC_START: begin
                n_head_ctl.op    = OP_START;
                n_head_ctl.drop  = r_ld_active;
                n_head_ctl.token = 1'b1;
            end
            FUNC_SAMPLE: begin
                if (r_ld_active) begin
                    n_head_ctl.op   = OP_SAMPLE;
                    n_head_ctl.last = (w_cnt_inc >= r_ld_len);
                end else begin
                    n_head_ctl.op = OP_NOP;
                    n_status      = STAT_IGNORED;
                end
            end
            FUNC_FREEZE: begin
                n_head_ctl.op   = OP_FREEZE;
                n_head_ctl.flag = w_rep;
            end
            default: begin
                n_head_ctl.op = OP_NOP;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_head_idx  <= r_ld_slot;
            r_head_len  <= w_len_x[LW-1:0];
            r_head_addr <= r_ld_cnt[AW-1:0];
            r_prod      <= $signed(w_smp) * $signed({1'b0, w_gain});
            r_status    <= n_status;
        end
    end

    // round half up, drop 15 fraction bits, saturate to the stored sample width
    logic signed [PW-1:0]    w_rnd;
    logic [SAMPLE_BITS-1:0]  w_head_smp;
    always_comb begin
        w_rnd = (r_prod + PW'(16384)) >>> 15;
        if (w_rnd > $signed(PW'(SMAX_I))) begin
            w_head_smp = SAMPLE_BITS'(SMAX_I);
        end else if (w_rnd < $signed(PW'(SMIN_I))) begin
            w_head_smp = SAMPLE_BITS'(SMIN_I);
        end else begin
            w_head_smp = w_rnd[SAMPLE_BITS-1:0];
        end
    end

    // chain of slot cells
    t_ctl                   w_ctl    [SLOTS+1];
    logic [IW-1:0]          w_idx    [SLOTS+1];
    logic [IW-1:0]          w_claim  [SLOTS+1];
    logic [SAMPLE_BITS-1:0] w_sample [SLOTS+1];
    logic [LW-1:0]          w_len    [SLOTS+1];
    logic [AW-1:0]          w_addr   [SLOTS+1];
    logic [SW-1:0]          w_sum    [SLOTS+1];

    assign w_ctl[0]    = r_head_ctl;
    assign w_idx[0]    = r_head_idx;
    assign w_claim[0]  = '0;
    assign w_sample[0] = w_head_smp;
    assign w_len[0]    = r_head_len;
    assign w_addr[0]   = r_head_addr;
    assign w_sum[0]    = '0;

    for (genvar g = 0; g < SLOTS; g++) begin : g_cell
        gvpm_cell #(
            .SLOTS       (SLOTS),
            .GRAIN_LEN   (GRAIN_LEN),
            .SAMPLE_BITS (SAMPLE_BITS),
            .MY_IDX      (g)
        ) u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_ctl    (w_ctl[g]),
            .i_idx    (w_idx[g]),
            .i_claim  (w_claim[g]),
            .i_sample (w_sample[g]),
            .i_len    (w_len[g]),
            .i_addr   (w_addr[g]),
            .i_sum    (w_sum[g]),
            .o_ctl    (w_ctl[g+1]),
            .o_idx    (w_idx[g+1]),
            .o_claim  (w_claim[g+1]),
            .o_sample (w_sample[g+1]),
            .o_len    (w_len[g+1]),
            .o_addr   (w_addr[g+1]),
            .o_sum    (w_sum[g+1])
        );
    end

    // tail of the chain: saturate the mix and settle the status
    t_ctl                 w_tail;
    logic signed [MXW-1:0] w_sum_x;
    logic [MIX_W-1:0]     w_mix;
    logic [STAT_W-1:0]    w_tail_status;

    assign w_tail  = w_ctl[SLOTS];
    assign w_sum_x = MXW'($signed(w_sum[SLOTS]));

    always_comb begin
        if (w_sum_x > $signed(MXW'(MIX_MAX))) begin
            w_mix = MIX_W'(MIX_MAX);
        end else if (w_sum_x < $signed(MXW'(MIX_MIN))) begin
            w_mix = MIX_W'(MIX_MIN);
        end else begin
            w_mix = w_sum_x[MIX_W-1:0];
        end
        if (w_tail.op == OP_START && w_tail.token) begin
            w_tail_status = STAT_FULL;
        end else begin
            w_tail_status = r_status;
        end
    end

    logic w_move;
    assign w_move = r_hold_valid && (!r_out_valid || m_axis_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy       <= 1'b0;
            r_head_ctl   <= '0;
            r_ld_active  <= 1'b0;
            r_ld_slot    <= '0;
            r_ld_cnt     <= '0;
            r_ld_len     <= '0;
            r_hold_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            // launch one word into the chain per accepted item
            if (w_acc) begin
                r_busy     <= 1'b1;
                r_head_ctl <= n_head_ctl;
            end else begin
                r_head_ctl.valid <= 1'b0;
            end

            // word leaves the last cell: update the loading state, hold the result
            if (w_tail.valid) begin
                r_hold_valid <= 1'b1;
                case (w_tail.op)
                    OP_START: begin
                        if (w_tail.token) begin
                            r_ld_active <= 1'b0;
                        end else begin
                            r_ld_active <= 1'b1;
                            r_ld_slot   <= w_claim[SLOTS];
                            r_ld_cnt    <= '0;
                            r_ld_len    <= w_len[SLOTS];
                        end
                    end
                    OP_SAMPLE: begin
                        if (w_tail.last) begin
                            r_ld_active <= 1'b0;
                            r_ld_cnt    <= '0;
                        end else begin
                            r_ld_cnt <= w_cnt_inc;
                        end
                    end
                    default: begin
                    end
                endcase
            end

            // hand the held result to the output register, then free the front
            if (w_move) begin
                r_out_valid  <= 1'b1;
                r_hold_valid <= 1'b0;
                r_busy       <= 1'b0;
            end else if (r_out_valid && m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_tail.valid) begin
            r_hold_mix    <= w_mix;
            r_hold_status <= w_tail_status;
        end
        if (w_move) begin
            r_out_mix    <= r_hold_mix;
            r_out_status <= r_hold_status;
        end
    end

    assign s_axis_tready = !r_busy;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(24 - MIX_W){1'b0}}, r_out_mix};
    assign m_axis_tuser  = r_out_status;

    `GVPM_ASSERT_NXT(a_accept_busy, w_acc, r_busy, "accepted word without busy")
    `GVPM_ASSERT_IMP(a_tail_busy, w_tail.valid, (r_busy && !r_hold_valid), "stray tail word")
    `GVPM_ASSERT_IMP(a_load_cnt, r_ld_active, (r_ld_cnt < r_ld_len), "load count overrun")

endmodule

[sim/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
    import gvpm_pkg::*;

    localparam int SLOTS        = 8;
    localparam int GRAIN_LEN    = 1024;
    localparam int SAMPLE_BITS  = 16;
    localparam int WORDS_WANTED = 1850;
    // Extra settling time after the last result, well beyond one word's walk through the block.
    localparam int DRAIN_CYCLES = 40;
    // Cycles with no handshake on either side before the run is declared hung.
    localparam int STALL_LIMIT  = 5000;
    localparam int HOLD_CYCLES  = 300;
    localparam int REPORT_CAP   = 100;

    typedef struct {
        logic [1:0]         func;
        logic [10:0]        glen;
        logic signed [15:0] smp;
        logic [15:0]        gain;
        logic               rep;
    } t_voice_word;

    typedef struct {
        logic signed [18:0] mix;
        logic [1:0]         status;
    } t_mix_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata = '0;   // grain_length, sample, envelope_gain, repeat_flag
    logic [1:0]  s_axis_tuser = '0;   // func
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;        // mix_sum
    logic [1:0]  m_axis_tuser;        // status

    grain_voice_pool_mixer_core #(
        .SLOTS       (SLOTS),
        .GRAIN_LEN   (GRAIN_LEN),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predicted pool state
    // ------------------------------------------------------------------
    logic signed [15:0] grain_mem [SLOTS*GRAIN_LEN];
    bit                 voice_busy  [SLOTS];
    bit                 voice_ready [SLOTS];
    bit                 voice_loop  [SLOTS];
    int unsigned        voice_pos   [SLOTS];
    int unsigned        voice_len   [SLOTS];
    int unsigned        load_slot;
    int unsigned        load_count;
    bit                 load_active;

    t_voice_word pending_words[$];
    t_mix_result mixes_due[$];

    bit word_taken;
    bit result_taken;
    int words_in;
    int results_in;
    int mismatches;
    int words_queued;
    int noise_samples;

    function automatic logic signed [15:0] apply_envelope(logic signed [15:0] smp,
                                                          logic [15:0] gain);
        longint s_l;
        longint g_l;
        longint q;
        s_l = smp;
        g_l = gain;
        // Round half up: floor of (s * g + half) / 2^15, by arithmetic shift.
        q = (s_l * g_l + 16384) >>> 15;
        if (q > 32767)
            q = 32767;
        if (q < -32768)
            q = -32768;
        return q[15:0];
    endfunction

    task automatic release_voice(int unsigned i);
        voice_busy[i]  = 1'b0;
        voice_ready[i] = 1'b0;
        voice_pos[i]   = 0;
        voice_loop[i]  = 1'b0;
    endtask

    task automatic predict_voice_pool(input t_voice_word w, output t_mix_result r);
        int          acc;
        int unsigned nlen;
        int unsigned i;
        int unsigned nxt;
        acc      = 0;
        r.status = STAT_OK;
        case (w.func)
            FUNC_TICK: begin
                for (i = 0; i < SLOTS; i++) begin
                    if (voice_busy[i] && voice_ready[i]) begin
                        acc += grain_mem[i*GRAIN_LEN + (voice_pos[i] % GRAIN_LEN)];
                        nxt = voice_pos[i] + 1;
                        if (nxt >= voice_len[i]) begin
                            // Wrap a looping grain; free a one-shot one.
                            if (voice_loop[i])
                                voice_pos[i] = 0;
                            else
                                release_voice(i);
                        end else begin
                            voice_pos[i] = nxt;
                        end
                    end
                end
                if (acc > MIX_MAX)
                    acc = MIX_MAX;
                if (acc < MIX_MIN)
                    acc = MIX_MIN;
            end
            FUNC_START: begin
                nlen = {21'b0, w.glen};
                if (nlen == 0)
                    nlen = 1;
                if (nlen > GRAIN_LEN)
                    nlen = GRAIN_LEN;
                // Drop a grain that never finished loading.
                if (load_active)
                    release_voice(load_slot);
                load_active = 1'b0;
                for (i = 0; i < SLOTS; i++)
                    if (!voice_busy[i])
                        break;
                if (i == SLOTS) begin
                    r.status = STAT_FULL;
                end else begin
                    voice_busy[i]  = 1'b1;
                    voice_ready[i] = 1'b0;
                    voice_pos[i]   = 0;
                    voice_len[i]   = nlen;
                    voice_loop[i]  = 1'b0;
                    load_slot      = i;
                    load_count     = 0;
                    load_active    = 1'b1;
                end
            end
            FUNC_SAMPLE: begin
                if (!load_active) begin
                    r.status = STAT_IGNORED;
                end else begin
                    grain_mem[load_slot*GRAIN_LEN + (load_count % GRAIN_LEN)] =
                        apply_envelope(w.smp, w.gain);
                    load_count++;
                    if (load_count >= voice_len[load_slot]) begin
                        voice_ready[load_slot] = 1'b1;
                        load_active = 1'b0;
                        load_count  = 0;
                    end
                end
            end
            default: begin
                for (i = 0; i < SLOTS; i++)
                    if (voice_busy[i])
                        voice_loop[i] = w.rep;
            end
        endcase
        r.mix = acc[18:0];
    endtask

    task automatic report_mismatch(string msg);
        if (mismatches < REPORT_CAP)
            $display("mismatch at %0t: %s", $time, msg);
        mismatches++;
    endtask

    task automatic queue_word(logic [1:0] func, logic [10:0] glen, logic [15:0] smp,
                              logic [15:0] gain, logic rep);
        t_voice_word w;
        w.func = func;
        w.glen = glen;
        w.smp  = smp;
        w.gain = gain;
        w.rep  = rep;
        pending_words.push_back(w);
        words_queued++;
    endtask

    // ------------------------------------------------------------------
    // Sender: present one word at a time, hold it until taken, then draw a gap.
    // Every fourth stretch of 150 words runs with no gaps at all.
    // ------------------------------------------------------------------
    int send_gap;

    always @(negedge i_clk) begin
        t_voice_word w;
        if (i_rst_n && !(s_axis_tvalid && !word_taken)) begin
            if (s_axis_tvalid)
                send_gap = ((words_in / 150) % 4 == 3) ? 0 : $urandom_range(0, 15);
            if (send_gap > 0) begin
                send_gap--;
                s_axis_tvalid <= 1'b0;
            end else if (pending_words.size() > 0) begin
                w = pending_words.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tuser  <= w.func;
                s_axis_tdata  <= {4'b0, w.rep, w.gain, w.smp, w.glen};
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: stall after each result for a drawn number of cycles, with a
    // calm stretch now and then. A few times in the run, hold off for a long
    // stretch so the block backs up and drops s_axis_tready.
    // ------------------------------------------------------------------
    int recv_gap;
    int long_hold;

    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (result_taken) begin
                recv_gap = ((results_in / 170) % 4 == 2) ? 0 : $urandom_range(0, 15);
                if (results_in % 700 == 350)
                    long_hold = HOLD_CYCLES;
            end
            if (long_hold > 0) begin
                long_hold--;
                m_axis_tready <= 1'b0;
            end else if (recv_gap > 0) begin
                recv_gap--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: predict on every word taken in, check every word handed out.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_voice_word w;
        t_mix_result r;
        t_mix_result due;
        word_taken   = i_rst_n && s_axis_tvalid && s_axis_tready;
        result_taken = i_rst_n && m_axis_tvalid && m_axis_tready;
        if (word_taken) begin
            w.func = s_axis_tuser;
            w.glen = s_axis_tdata[10:0];
            w.smp  = s_axis_tdata[26:11];
            w.gain = s_axis_tdata[42:27];
            w.rep  = s_axis_tdata[43];
            predict_voice_pool(w, r);
            mixes_due.push_back(r);
            words_in++;
        end
        if (result_taken) begin
            results_in++;
            if (mixes_due.size() == 0) begin
                report_mismatch($sformatf("result %0d arrived with nothing due", results_in));
            end else begin
                due = mixes_due.pop_front();
                if (m_axis_tdata[18:0] !== due.mix)
                    report_mismatch($sformatf("result %0d mix_sum %0d, predicted %0d",
                        results_in, $signed(m_axis_tdata[18:0]), due.mix));
                if (m_axis_tuser !== due.status)
                    report_mismatch($sformatf("result %0d status %0d, predicted %0d",
                        results_in, m_axis_tuser, due.status));
            end
        end
    end

    // Watchdog: give up when neither side has moved a word for too long.
    int quiet_cycles;

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------
    initial begin
        int          pick;
        int          lsel;
        int unsigned glen;
        int unsigned nsmp;
        int          k;
        logic [15:0] gain;
        logic [1:0]  func;

        // Directed part: empty pool, clamped lengths, drop while loading,
        // loop mark on the loading grain, saturation, full pool.
        queue_word(FUNC_SAMPLE, 11'h7FF, 16'h8000, 16'hFFFF, 1'b1);   // nothing loading
        queue_word(FUNC_TICK, 11'h000, 16'h0000, 16'h0000, 1'b0);     // silent pool
        queue_word(FUNC_START, 11'h7FF, 16'h0000, 16'h0000, 1'b0);    // clamp to GRAIN_LEN
        queue_word(FUNC_FREEZE, 11'h000, 16'h0000, 16'h0000, 1'b1);   // marks loading grain
        queue_word(FUNC_START, 11'h000, 16'h0000, 16'h0000, 1'b0);    // drop it, length 0 -> 1
        queue_word(FUNC_SAMPLE, 11'h000, 16'h8000, 16'hFFFF, 1'b0);   // saturates low
        for (k = 1; k < SLOTS; k++) begin
            queue_word(FUNC_START, 11'd1, 16'($urandom), 16'($urandom), 1'($urandom));
            case (k)
                1:       queue_word(FUNC_SAMPLE, 11'($urandom), 16'h7FFF, 16'hFFFF, 1'b0);
                2:       queue_word(FUNC_SAMPLE, 11'($urandom), 16'h7FFF, 16'h8000, 1'b1);
                3:       queue_word(FUNC_SAMPLE, 11'($urandom), 16'h8000, 16'h0000, 1'b0);
                4:       queue_word(FUNC_SAMPLE, 11'($urandom), 16'h5555, 16'hAAAA, 1'b0);
                default: queue_word(FUNC_SAMPLE, 11'($urandom), 16'h8000, 16'h8000, 1'b0);
            endcase
        end
        queue_word(FUNC_FREEZE, 11'h000, 16'h0000, 16'h0000, 1'b1);   // loop every grain
        queue_word(FUNC_START, 11'd5, 16'h0000, 16'h0000, 1'b0);      // pool full
        queue_word(FUNC_TICK, 11'h000, 16'h0000, 16'h0000, 1'b0);
        queue_word(FUNC_FREEZE, 11'h000, 16'h0000, 16'h0000, 1'b0);   // back to one-shot
        queue_word(FUNC_TICK, 11'h000, 16'h0000, 16'h0000, 1'b0);     // plays, then frees
        queue_word(FUNC_TICK, 11'h000, 16'h0000, 16'h0000, 1'b0);

        // Random part: mostly well-formed grains with ticks and freezes woven in,
        // the rest bursts of ticks, freezes and noise.
        while (words_queued - noise_samples < WORDS_WANTED) begin
            pick = $urandom_range(0, 99);
            if (pick < 65) begin
                lsel = $urandom_range(0, 99);
                if (lsel < 1)
                    glen = $urandom_range(129, 2047);
                else if (lsel < 11)
                    glen = $urandom_range(17, 128);
                else
                    glen = $urandom_range(1, 16);
                nsmp = (glen > GRAIN_LEN) ? GRAIN_LEN : glen;
                // Cut a few grains short so the next start drops them.
                if ($urandom_range(0, 99) < 8)
                    nsmp = $urandom_range(0, nsmp - 1);
                queue_word(FUNC_START, 11'(glen), 16'($urandom), 16'($urandom),
                           1'($urandom));
                for (k = 0; k < nsmp; k++) begin
                    if ($urandom_range(0, 9) == 0)
                        queue_word(FUNC_TICK, 11'($urandom), 16'($urandom), 16'($urandom),
                                   1'($urandom));
                    else if ($urandom_range(0, 39) == 0)
                        queue_word(FUNC_FREEZE, 11'($urandom), 16'($urandom), 16'($urandom),
                                   $urandom_range(0, 2) == 0);
                    gain = ($urandom_range(0, 19) == 0) ? 16'($urandom_range(32769, 65535))
                                                        : 16'($urandom_range(0, 32768));
                    queue_word(FUNC_SAMPLE, 11'($urandom), 16'($urandom), gain, 1'($urandom));
                end
            end else if (pick < 85) begin
                for (k = $urandom_range(1, 12); k > 0; k--)
                    queue_word(FUNC_TICK, 11'($urandom), 16'($urandom), 16'($urandom),
                               1'($urandom));
            end else if (pick < 90) begin
                queue_word(FUNC_FREEZE, 11'($urandom), 16'($urandom), 16'($urandom),
                           $urandom_range(0, 2) == 0);
            end else begin
                func = 2'($urandom);
                queue_word(func, 11'($urandom), 16'($urandom), 16'($urandom), 1'($urandom));
                if (func == FUNC_SAMPLE)
                    noise_samples++;
            end
        end

        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Wait for the sender to empty out and every result to come back.
        while (pending_words.size() != 0 || s_axis_tvalid || mixes_due.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
